/* design/atrtd_pkg.sv */
// ----------------------------------------------------------------------------
// atrtd_pkg
// Shared types, sizes and character constants for the modem reply classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package atrtd_pkg;

   // response buffer size in bytes and the width of a buffer position
   localparam int BUFFER_SIZE = 256;
   localparam int PosW        = $clog2(BUFFER_SIZE + 1);
   localparam int WinLen      = 9;

   typedef logic [PosW-1:0] pos_type;
   typedef logic [7:0]      byte_type;
   typedef logic [2:0]      status_type;
   typedef logic [1:0]      kind_type;

   // terminator kinds, also the status codes below reboot
   localparam kind_type KIND_NONE   = 2'd0;
   localparam kind_type KIND_OK     = 2'd1;
   localparam kind_type KIND_ERROR  = 2'd2;
   localparam kind_type KIND_NOTICE = 2'd3;

   localparam status_type STATUS_REBOOT = 3'd4;

   localparam pos_type  START_NONE  = '1;
   localparam byte_type CH_CR       = 8'h0D;
   localparam byte_type CH_LF       = 8'h0A;
   localparam int       RebootLen   = 12;
   localparam int       OkLen       = 6;
   localparam int       NoticeMinLen = 14;

   // CR LF OK CR LF, oldest first
   localparam byte_type OK_SEQ [OkLen] = '{8'h0D, 8'h0A, 8'h4F, 8'h4B, 8'h0D, 8'h0A};
   // CR LF ERROR CR LF
   localparam byte_type ERR_SEQ [WinLen] =
      '{8'h0D, 8'h0A, 8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h0D, 8'h0A};
   // "+NSONMI: "
   localparam byte_type HDR_SEQ [WinLen] =
      '{8'h2B, 8'h4E, 8'h53, 8'h4F, 8'h4E, 8'h4D, 8'h49, 8'h3A, 8'h20};

   // one input word and one result word
   typedef struct packed {
      logic     clear;
      byte_type rx_byte;
   } item_type;

   typedef struct packed {
      status_type status;
      logic       overflow;
   } result_type;

   // characters of the reboot notice text by match position
   function automatic byte_type reboot_char(input logic [3:0] idx);
      byte_type c;
      case (idx)
         4'd0:    c = 8'h52; // R
         4'd1:    c = 8'h45; // E
         4'd2:    c = 8'h42; // B
         4'd3:    c = 8'h4F; // O
         4'd4:    c = 8'h4F; // O
         4'd5:    c = 8'h54; // T
         4'd6:    c = 8'h5F; // _
         4'd7:    c = 8'h43; // C
         4'd8:    c = 8'h41; // A
         4'd9:    c = 8'h55; // U
         4'd10:   c = 8'h53; // S
         4'd11:   c = 8'h45; // E
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

/* design/atrtd_if.sv */
// ----------------------------------------------------------------------------
// atrtd_if
// Valid/ready channels for received bytes and classification results.
// ----------------------------------------------------------------------------
`default_nettype none

interface atrtd_req_if;
   import atrtd_pkg::*;
   logic     valid;
   logic     ready;
   logic     clear;
   byte_type rx_byte;

   modport source (output valid, clear, rx_byte, input ready);
   modport sink   (input valid, clear, rx_byte, output ready);
endinterface

interface atrtd_rsp_if;
   import atrtd_pkg::*;
   logic       valid;
   logic       ready;
   status_type status;
   logic       overflow;

   modport source (output valid, status, overflow, input ready);
   modport sink   (input valid, status, overflow, output ready);
endinterface

`default_nettype wire

/* design/atrtd_match.sv */
// ----------------------------------------------------------------------------
// atrtd_match
// Matcher state and one-pass classification of each appended byte.
// ----------------------------------------------------------------------------
`default_nettype none

module atrtd_match import atrtd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  item_type   item,
   output result_type result
);

   byte_type    window_ff [WinLen];
   pos_type     fill_ff;
   logic [3:0]  reboot_prog_ff;
   logic        reboot_seen_ff;
   logic        notice_pend_ff;
   pos_type     notice_start_ff;
   logic        notice_crlf_ff;
   pos_type     best_start_ff;
   kind_type    best_kind_ff;

   byte_type    window_in [WinLen];
   pos_type     fill_in;
   logic [3:0]  reboot_prog_in;
   logic        reboot_seen_in;
   logic        notice_pend_in;
   pos_type     notice_start_in;
   logic        notice_crlf_in;
   pos_type     best_start_in;
   kind_type    best_kind_in;

   byte_type    win_next [WinLen];
   logic        ok_hit;
   logic        err_hit;
   logic        hdr_hit;
   logic [PosW:0] notice_end;

   // next state for one byte
   always_comb begin
      // clear first, then append
      if (item.clear) begin
         for (int i = 0; i < WinLen; i++) window_in[i] = '0;
         fill_in         = '0;
         reboot_prog_in  = '0;
         reboot_seen_in  = 1'b0;
         notice_pend_in  = 1'b0;
         notice_start_in = '0;
         notice_crlf_in  = 1'b0;
         best_start_in   = START_NONE;
         best_kind_in    = KIND_NONE;
      end else begin
         for (int i = 0; i < WinLen; i++) window_in[i] = window_ff[i];
         fill_in         = fill_ff;
         reboot_prog_in  = reboot_prog_ff;
         reboot_seen_in  = reboot_seen_ff;
         notice_pend_in  = notice_pend_ff;
         notice_start_in = notice_start_ff;
         notice_crlf_in  = notice_crlf_ff;
         best_start_in   = best_start_ff;
         best_kind_in    = best_kind_ff;
      end

      // window as it stands once the byte is appended
      for (int i = 0; i < WinLen - 1; i++) win_next[i] = window_in[i + 1];
      win_next[WinLen - 1] = item.rx_byte;

      ok_hit     = 1'b0;
      err_hit    = 1'b0;
      hdr_hit    = 1'b0;
      notice_end = '0;
      result.overflow = 1'b0;

      if (fill_in >= pos_type'(BUFFER_SIZE)) begin
         // buffer full: drop the byte
         result.overflow = 1'b1;
      end else begin
         // window compares on the appended window
         ok_hit  = (fill_in >= pos_type'(OkLen - 1));
         err_hit = (fill_in >= pos_type'(WinLen - 1));
         hdr_hit = (fill_in >= pos_type'(WinLen - 1)) && !notice_pend_in;
         for (int i = 0; i < WinLen; i++) begin
            if (win_next[i] != ERR_SEQ[i]) err_hit = 1'b0;
            if (win_next[i] != HDR_SEQ[i]) hdr_hit = 1'b0;
         end
         for (int i = 0; i < OkLen; i++) begin
            if (win_next[WinLen - OkLen + i] != OK_SEQ[i]) ok_hit = 1'b0;
         end

         // CR LF after an open header
         if (notice_pend_in && window_in[WinLen - 1] == CH_CR && item.rx_byte == CH_LF)
            notice_crlf_in = 1'b1;

         // reboot text, restart on a fresh R
         if (item.rx_byte == reboot_char(reboot_prog_in))
            reboot_prog_in = reboot_prog_in + 4'd1;
         else if (item.rx_byte == reboot_char(4'd0))
            reboot_prog_in = 4'd1;
         else
            reboot_prog_in = 4'd0;
         if (reboot_prog_in >= 4'(RebootLen)) begin
            reboot_seen_in = 1'b1;
            reboot_prog_in = 4'd0;
         end

         if (hdr_hit) begin
            notice_pend_in  = 1'b1;
            notice_start_in = fill_in - pos_type'(WinLen - 1);
            notice_crlf_in  = 1'b0;
         end

         // earliest-starting terminator wins
         if (ok_hit && (best_kind_in == KIND_NONE ||
                        fill_in - pos_type'(OkLen - 1) < best_start_in)) begin
            best_start_in = fill_in - pos_type'(OkLen - 1);
            best_kind_in  = KIND_OK;
         end
         if (err_hit && (best_kind_in == KIND_NONE ||
                         fill_in - pos_type'(WinLen - 1) < best_start_in)) begin
            best_start_in = fill_in - pos_type'(WinLen - 1);
            best_kind_in  = KIND_ERROR;
         end

         for (int i = 0; i < WinLen; i++) window_in[i] = win_next[i];
         fill_in = fill_in + pos_type'(1);

         notice_end = {1'b0, notice_start_in} + (PosW + 1)'(NoticeMinLen);
         if (notice_pend_in && notice_crlf_in && {1'b0, fill_in} >= notice_end &&
             (best_kind_in == KIND_NONE || notice_start_in < best_start_in)) begin
            best_start_in = notice_start_in;
            best_kind_in  = KIND_NOTICE;
         end
      end

      result.status = reboot_seen_in ? STATUS_REBOOT : {1'b0, best_kind_in};
   end

   // matcher state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WinLen; i++) window_ff[i] <= '0;
         fill_ff         <= '0;
         reboot_prog_ff  <= '0;
         reboot_seen_ff  <= 1'b0;
         notice_pend_ff  <= 1'b0;
         notice_start_ff <= '0;
         notice_crlf_ff  <= 1'b0;
         best_start_ff   <= START_NONE;
         best_kind_ff    <= KIND_NONE;
      end else if (step) begin
         for (int i = 0; i < WinLen; i++) window_ff[i] <= window_in[i];
         fill_ff         <= fill_in;
         reboot_prog_ff  <= reboot_prog_in;
         reboot_seen_ff  <= reboot_seen_in;
         notice_pend_ff  <= notice_pend_in;
         notice_start_ff <= notice_start_in;
         notice_crlf_ff  <= notice_crlf_in;
         best_start_ff   <= best_start_in;
         best_kind_ff    <= best_kind_in;
      end
   end

endmodule

`default_nettype wire

/* design/at_response_terminator_detect.sv */
// ----------------------------------------------------------------------------
// at_response_terminator_detect
// Classifies a modem reply byte stream: ok, error, data notice or reboot.
// ----------------------------------------------------------------------------
//  channel | dir | words                     | handshake
//  req     | in  | clear, rx_byte            | valid/ready
//  rsp     | out | status, overflow          | valid/ready
//
//  One word per cycle sustained while rsp takes words; a byte is taken into the
//  input register, then one pass of matching writes its result into the result reg.
//  Synchronous reset empties the buffer and all matchers.
//  A stalled rsp holds its word; req keeps taking words while the input
//  register is empty or can drain into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module at_response_terminator_detect import atrtd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   atrtd_req_if.sink   req,
   atrtd_rsp_if.source rsp
);

   logic       in_valid_ff;
   item_type   in_item_ff;
   logic       rsp_valid_ff;
   result_type rsp_word_ff;

   logic       in_valid_in;
   logic       rsp_valid_in;
   logic       advance;
   result_type match_word;

   // stage advance when the result register is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req.valid && req.ready) in_valid_in = 1'b1;
      else if (advance)           in_valid_in = 1'b0;
      rsp_valid_in = rsp_valid_ff;
      if (advance)        rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
   end

   atrtd_match u_match (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_item_ff),
      .result (match_word)
   );

   // input and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req.valid && req.ready) begin
         in_item_ff.clear   <= req.clear;
         in_item_ff.rx_byte <= req.rx_byte;
      end
      if (advance) rsp_word_ff <= match_word;
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.status   = rsp_word_ff.status;
   assign rsp.overflow = rsp_word_ff.overflow;

endmodule

`default_nettype wire

/* tb/sv/tb_at_response_terminator_detect.sv */
// ----------------------------------------------------------------------------
// tb_at_response_terminator_detect
// Self-checking bench for the modem reply classifier. Reply bytes go in over
// the req channel with random gaps; every result word on rsp is compared
// against an in-bench classifier that tracks the buffer, the reboot matcher,
// the data notice header and the earliest complete terminator. Directed
// replies come first, then a buffer overflow run, then random replies.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_at_response_terminator_detect;
   import atrtd_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int ItemsTarget = 1850;
   localparam int QuietLimit  = 2000;  // cycles with no word moving on either side
   localparam int TailCycles  = 8;     // margin to watch for stray result words
   localparam int MaxGap      = 17;

   localparam logic [47:0] OK_TEXT     = {CH_CR, CH_LF, "OK", CH_CR, CH_LF};
   localparam logic [71:0] ERROR_TEXT  = {CH_CR, CH_LF, "ERROR", CH_CR, CH_LF};
   localparam logic [71:0] HEADER_TEXT = "+NSONMI: ";
   // reboot notice text, first character in the top byte
   localparam logic [95:0] REBOOT_TEXT = {8'h52, 8'h45, 8'h42, 8'h4F, 8'h4F, 8'h54,
                                          8'h5F, 8'h43, 8'h41, 8'h55, 8'h53, 8'h45};

   logic clock;
   logic reset;

   atrtd_req_if req_ch ();
   atrtd_rsp_if rsp_ch ();

   at_response_terminator_detect dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   // classifier copy kept by the bench
   logic [71:0] window_bytes;   // newest byte in the low eight bits
   int          buf_fill;
   logic [3:0]  reboot_idx;
   logic        reboot_found;
   logic        header_found;
   pos_type     header_pos;
   logic        header_crlf;
   pos_type     term_pos;
   kind_type    term_kind;

   result_type  expected_results [$];
   byte_type    reply_q [$];

   bit burst;          // no idling on either side while set
   int taken_bytes;    // bytes that went into the buffer
   int failures;
   int results_seen;
   int status_seen [8];
   int overflow_seen;
   int quiet_cycles;

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic log_failure(input string msg);
      failures++;
      if (failures <= 10) $display("ERROR: %s", msg);
   endtask

   function automatic void clear_classifier();
      window_bytes = '0;
      buf_fill     = 0;
      reboot_idx   = '0;
      reboot_found = 1'b0;
      header_found = 1'b0;
      header_pos   = '0;
      header_crlf  = 1'b0;
      term_pos     = START_NONE;
      term_kind    = KIND_NONE;
   endfunction

   function automatic void offer_terminator(input int start, input kind_type kind);
      if (term_kind == KIND_NONE || start < int'(term_pos)) begin
         term_pos  = pos_type'(start);
         term_kind = kind;
      end
   endfunction

   function automatic status_type current_class();
      if (reboot_found) return STATUS_REBOOT;
      return status_type'(term_kind);
   endfunction

   // one byte through the classifier, returns the result word it causes
   function automatic result_type classify_byte(input logic clr, input byte_type b);
      result_type r;
      int         p;
      byte_type   want;
      if (clr) clear_classifier();
      if (buf_fill >= BUFFER_SIZE) begin
         r.status   = current_class();
         r.overflow = 1'b1;
         return r;
      end
      window_bytes = {window_bytes[63:0], b};
      p = buf_fill;
      buf_fill++;

      // substring search; a mismatch on 'R' restarts at one
      want = REBOOT_TEXT[95 - 8*reboot_idx -: 8];
      if (b == want) reboot_idx = reboot_idx + 4'd1;
      else reboot_idx = (b == REBOOT_TEXT[95 -: 8]) ? 4'd1 : 4'd0;
      if (reboot_idx >= RebootLen) begin
         reboot_found = 1'b1;
         reboot_idx   = '0;
      end

      // CR LF behind an already seen header
      if (header_found && window_bytes[15:8] == CH_CR && b == CH_LF) header_crlf = 1'b1;

      // only the earliest header counts
      if (p >= 8 && window_bytes == HEADER_TEXT && !header_found) begin
         header_found = 1'b1;
         header_pos   = pos_type'(p - 8);
         header_crlf  = 1'b0;
      end

      if (p >= 5 && window_bytes[47:0] == OK_TEXT) offer_terminator(p - 5, KIND_OK);
      if (p >= 8 && window_bytes == ERROR_TEXT) offer_terminator(p - 8, KIND_ERROR);
      if (header_found && header_crlf && buf_fill >= int'(header_pos) + NoticeMinLen)
         offer_terminator(int'(header_pos), KIND_NOTICE);

      r.status   = current_class();
      r.overflow = 1'b0;
      return r;
   endfunction

   // predict on every accepted byte
   always @(posedge clock) begin
      result_type r;
      if (!reset && req_ch.valid && req_ch.ready) begin
         r = classify_byte(req_ch.clear, req_ch.rx_byte);
         if (!r.overflow) taken_bytes++;
         expected_results.push_back(r);
      end
   end

   // check every accepted result word against the oldest prediction
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         status_seen[rsp_ch.status]++;
         if (rsp_ch.overflow === 1'b1) overflow_seen++;
         if (expected_results.size() == 0) begin
            log_failure($sformatf("result word status=%0d overflow=%0b with none expected",
                                  rsp_ch.status, rsp_ch.overflow));
         end else begin
            want = expected_results.pop_front();
            if (rsp_ch.status !== want.status)
               log_failure($sformatf("result %0d status: expected %0d, got %0d",
                                     results_seen, want.status, rsp_ch.status));
            if (rsp_ch.overflow !== want.overflow)
               log_failure($sformatf("result %0d overflow: expected %0b, got %0b",
                                     results_seen, want.overflow, rsp_ch.overflow));
         end
      end
   end

   // watchdog on cycles where nothing moves
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("watchdog: no word moved for %0d cycles", QuietLimit);
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result side: stall a random number of cycles before each word
   initial begin
      int gap;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = burst ? 0 : $urandom_range(0, MaxGap);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // one word on req; returns at the edge that took it, valid still high
   task automatic send_word(input logic clr, input byte_type b);
      int gap;
      gap = burst ? 0 : $urandom_range(0, MaxGap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.clear   <= clr;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic idle_req();
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic pause_until_drained();
      idle_req();
      while (expected_results.size() != 0) @(posedge clock);
      repeat ($urandom_range(1, 5)) @(posedge clock);
   endtask

   // reply text builders
   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) reply_q.push_back(s[i]);
   endtask

   task automatic add_reboot();
      for (int i = 0; i < RebootLen; i++) reply_q.push_back(REBOOT_TEXT[95 - 8*i -: 8]);
   endtask

   task automatic add_crlf();
      reply_q.push_back(CH_CR);
      reply_q.push_back(CH_LF);
   endtask

   task automatic add_ok();
      add_crlf();
      add_text("OK");
      add_crlf();
   endtask

   task automatic add_error();
      add_crlf();
      add_text("ERROR");
      add_crlf();
   endtask

   // bytes biased toward the characters the matchers look at
   function automatic byte_type pick_byte();
      string chars;
      chars = "OKERBT_CAUSN+MI: 0,";
      case ($urandom_range(0, 9))
         0:       return CH_CR;
         1:       return CH_LF;
         2, 3, 4: return chars[$urandom_range(0, chars.len() - 1)];
         default: return byte_type'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic add_noise(input int n);
      repeat (n) reply_q.push_back(pick_byte());
   endtask

   task automatic add_digits(input int n);
      string d;
      d = "0123456789,";
      repeat (n) reply_q.push_back(d[$urandom_range(0, d.len() - 1)]);
   endtask

   // a terminator, header or reboot text cut short, sometimes with one byte spoiled
   task automatic add_broken();
      int base;
      int cut;
      base = reply_q.size();
      case ($urandom_range(0, 3))
         0:       add_ok();
         1:       add_error();
         2:       add_text("+NSONMI: ");
         default: add_reboot();
      endcase
      cut = $urandom_range(1, reply_q.size() - base - 1);
      while (reply_q.size() > base + cut) void'(reply_q.pop_back());
      if ($urandom_range(0, 2) == 0)
         reply_q[$urandom_range(base, reply_q.size() - 1)] = byte_type'($urandom_range(0, 255));
   endtask

   task automatic send_reply(input bit clear_first, input bit stray_clears);
      logic clr;
      for (int i = 0; i < reply_q.size(); i++) begin
         clr = (i == 0) ? clear_first : (stray_clears && $urandom_range(0, 63) == 0);
         send_word(clr, reply_q[i]);
      end
   endtask

   task automatic build_random_reply();
      reply_q.delete();
      add_noise($urandom_range(0, 6));
      case ($urandom_range(0, 9))
         0, 1: add_ok();
         2:    add_error();
         3, 4: begin
            add_text("+NSONMI: ");
            add_digits($urandom_range(0, 8));
            if ($urandom_range(0, 4) != 0) add_crlf();
            if ($urandom_range(0, 2) == 0) add_ok();
         end
         5: begin
            repeat ($urandom_range(0, 2)) add_text("R");
            if ($urandom_range(0, 1) == 1) add_text("REBOO");
            add_reboot();
            if ($urandom_range(0, 1) == 1) add_ok();
         end
         6: begin
            add_broken();
            add_noise($urandom_range(0, 4));
         end
         7: begin
            case ($urandom_range(0, 2))
               0: begin add_ok(); add_error(); end
               1: begin add_error(); add_ok(); end
               default: begin
                  add_text("+NSONMI: ");
                  add_digits($urandom_range(0, 6));
                  add_error();
               end
            endcase
         end
         8: add_noise($urandom_range(1, 20));
         default: begin
            if ($urandom_range(0, 7) == 0) begin
               add_noise(BUFFER_SIZE + $urandom_range(0, 8));
            end else begin
               add_noise($urandom_range(20, 40));
               add_ok();
            end
         end
      endcase
      add_noise($urandom_range(0, 3));
   endtask

   // field extremes and clear with a byte
   task automatic test_extremes();
      send_word(1'b1, 8'h00);
      send_word(1'b0, 8'hFF);
      send_word(1'b1, 8'hFF);
      send_word(1'b0, 8'h00);
   endtask

   // error completes first; the later ok has a larger start and loses
   task automatic test_terminators();
      reply_q.delete();
      add_error();
      add_text("OK");
      add_crlf();
      send_reply(1'b1, 1'b0);
   endtask

   // notice reaches 14 bytes, then a reboot with a doubled 'R' overrides it
   task automatic test_notice_reboot();
      reply_q.delete();
      add_text("+NSONMI: 0");
      add_crlf();
      add_text("R");
      add_reboot();
      send_reply(1'b1, 1'b0);
   endtask

   // fill the buffer to the last byte, then keep sending
   task automatic test_overflow();
      reply_q.delete();
      repeat (BUFFER_SIZE - OkLen) reply_q.push_back(byte_type'($urandom_range(0, 255)));
      add_ok();
      repeat (4) reply_q.push_back(byte_type'($urandom_range(0, 255)));
      send_reply(1'b1, 1'b0);
      // clear arriving with a full buffer still takes its byte
      reply_q.delete();
      repeat (BUFFER_SIZE + 3) reply_q.push_back(byte_type'($urandom_range(0, 255)));
      send_reply(1'b1, 1'b0);
   endtask

   // back-to-back reply, then the sender holds until every result is back
   task automatic test_drain_pause();
      burst = 1'b1;
      build_random_reply();
      send_reply(1'b1, 1'b0);
      pause_until_drained();
      burst = 1'b0;
   endtask

   task automatic test_random_replies();
      while (taken_bytes < ItemsTarget) begin
         if ($urandom_range(0, 3) == 0) burst = ~burst;
         build_random_reply();
         send_reply($urandom_range(0, 7) != 0, 1'b1);
         if ($urandom_range(0, 49) == 0) pause_until_drained();
      end
      burst = 1'b0;
   endtask

   initial begin
      clear_classifier();
      burst         = 1'b0;
      taken_bytes   = 0;
      failures      = 0;
      results_seen  = 0;
      overflow_seen = 0;
      quiet_cycles  = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
      reset          <= 1'b1;
      req_ch.valid   <= 1'b0;
      req_ch.clear   <= 1'b0;
      req_ch.rx_byte <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_terminators();
      test_notice_reboot();
      test_overflow();
      test_drain_pause();
      test_random_replies();

      // let the pipeline empty, then watch for stray words
      idle_req();
      while (expected_results.size() != 0) @(posedge clock);
      repeat (TailCycles) @(posedge clock);
      if (expected_results.size() != 0)
         log_failure($sformatf("%0d results still expected at end", expected_results.size()));

      $display("covered %0d buffered bytes, %0d result words, %0d dropped on full buffer",
               taken_bytes, results_seen, overflow_seen);
      $display("status counts: none %0d, ok %0d, error %0d, notice %0d, reboot %0d",
               status_seen[KIND_NONE], status_seen[KIND_OK], status_seen[KIND_ERROR],
               status_seen[KIND_NOTICE], status_seen[STATUS_REBOOT]);
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* files.f */
design/atrtd_pkg.sv
design/atrtd_if.sv
design/atrtd_match.sv
design/at_response_terminator_detect.sv
tb/sv/tb_at_response_terminator_detect.sv
